// File: rtl/sgb_pkg.sv
`default_nettype none
package sgb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(FRAME_BYTES);
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_PITCH   = 5 + 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic start_item;
        logic sweep_init;
        logic sweep_step;
        logic draw_init;
        logic col_start;
        logic col_step;
        logic page_rd;
        logic page_wr;
        logic page_next;
        logic x_step;
        logic draw_end;
        logic read_issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic draw_skip;
        logic bit_last;
        logic page_last;
        logic page_hit;
        logic sx_last;
        logic gcol_last;
        logic out_free;
    } t_dp_sts;

    // Maps a character code to its font entry; unknown codes give the blank.
    function automatic logic [5:0] glyph_index(input logic [7:0] c);
        logic [5:0] idx;
        idx = 6'd0;
        if (c >= 8'd32 && c <= 8'd58) begin
            idx = 6'(c - 8'd32);
        end else if (c >= 8'd65 && c <= 8'd90) begin
            idx = 6'(c - 8'd38);
        end else if (c == 8'd91) begin
            idx = 6'd53;
        end else if (c == 8'd93) begin
            idx = 6'd54;
        end
        return idx;
    endfunction

    // Five column bytes, column 0 in the low byte, bit 0 is the top row.
    function automatic logic [39:0] glyph_bits(input logic [5:0] idx);
        logic [39:0] g;
        case (idx)
            6'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            6'd1:  g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
            6'd2:  g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
            6'd3:  g = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
            6'd4:  g = {8'h12, 8'h2A, 8'h7F, 8'h2A, 8'h24};
            6'd5:  g = {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
            6'd6:  g = {8'h50, 8'h22, 8'h55, 8'h49, 8'h36};
            6'd7:  g = {8'h00, 8'h00, 8'h03, 8'h05, 8'h00};
            6'd8:  g = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
            6'd9:  g = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
            6'd10: g = {8'h14, 8'h08, 8'h3E, 8'h08, 8'h14};
            6'd11: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
            6'd12: g = {8'h00, 8'h00, 8'h30, 8'h50, 8'h00};
            6'd13: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            6'd14: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
            6'd15: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
            6'd16: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            6'd17: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            6'd18: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            6'd19: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            6'd20: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            6'd21: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            6'd22: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            6'd23: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            6'd24: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            6'd25: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            6'd26: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
            6'd27: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            6'd28: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
            6'd29: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            6'd30: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            6'd31: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
            6'd32: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
            6'd33: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
            6'd34: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            6'd35: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            6'd36: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
            6'd37: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
            6'd38: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            6'd39: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            6'd40: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
            6'd41: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            6'd42: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            6'd43: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
            6'd44: g = {8'h66, 8'h19, 8'h09, 8'h09, 8'h7F};
            6'd45: g = {8'h32, 8'h49, 8'h49, 8'h49, 8'h26};
            6'd46: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            6'd47: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            6'd48: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            6'd49: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            6'd50: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            6'd51: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            6'd52: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
            6'd53: g = {8'h3F, 8'h20, 8'h20, 8'h20, 8'h3F};
            6'd54: g = {8'h3F, 8'h04, 8'h04, 8'h04, 8'h3F};
            default: g = 40'd0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sgb_ram.sv
`default_nettype none
module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/sgb_datapath.sv
`default_nettype none
module sgb_datapath
    import sgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [7:0]        i_char_code,
    input  wire logic signed [7:0] i_pos_x,
    input  wire logic signed [6:0] i_pos_y,
    input  wire logic [2:0]        i_scale,
    input  wire logic              i_first_char,
    input  wire logic [9:0]        i_byte_addr,
    input  wire logic              i_rotate,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [7:0]             o_read_data
);
    localparam int COL_W = PAGE_COUNT * 8;

    logic signed [9:0]  r_cursor, n_cursor;
    logic signed [6:0]  r_row;
    logic [2:0]         r_scale;
    logic               r_full;
    logic [5:0]         r_gidx;
    logic [2:0]         r_gcol;
    logic [2:0]         r_sx;
    logic [2:0]         r_bit;
    logic signed [8:0]  r_offset;
    logic [COL_W-1:0]   r_column;
    logic signed [9:0]  r_x;
    logic [2:0]         r_page;
    logic [ADDR_W-1:0]  r_sweep;
    logic               r_rot_rd;
    logic               r_out_valid;
    logic [7:0]         r_out_data;

    logic [39:0]        w_glyph;
    logic [7:0]         w_gbyte;
    logic [7:0]         w_mask;
    logic signed [8:0]  w_sh;
    logic [COL_W+7:0]   w_ext;
    logic [7:0]         w_page_bits;
    logic               w_x_in;
    logic [ADDR_W-1:0]  w_page_addr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [7:0]         w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [7:0]         w_rdata;

    assign w_glyph     = glyph_bits(r_gidx);
    assign w_gbyte     = w_glyph[{r_gcol, 3'b000} +: 8];
    assign w_mask      = ~(8'hFF << r_scale);
    assign w_sh        = r_offset + 9'sd8;
    assign w_ext       = w_sh[8] ? '0 : ({{COL_W{1'b0}}, w_mask} << w_sh[6:0]);
    assign w_page_bits = r_column[{r_page, 3'b000} +: 8];
    assign w_x_in      = (r_x[9:7] == 3'b000);
    assign w_page_addr = {r_page, r_x[6:0]};
    assign n_cursor    = r_cursor + 10'(GLYPH_PITCH * r_scale);

    assign w_we    = i_cmd.sweep_step | i_cmd.page_wr;
    assign w_waddr = i_cmd.sweep_step ? r_sweep : w_page_addr;
    assign w_wdata = i_cmd.sweep_step ? 8'd0 : (w_rdata | w_page_bits);
    // A half-turn read of the frame is the mirrored address with its bits reversed.
    assign w_raddr = i_cmd.read_issue ? (i_rotate ? ~i_byte_addr : i_byte_addr) : w_page_addr;

    sgb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.read_issue | i_cmd.page_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_row       <= '0;
            r_scale     <= 3'd1;
            r_full      <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_item) begin
                r_gidx <= glyph_index(i_char_code);
                if (i_first_char) begin
                    r_cursor <= 10'(i_pos_x);
                    r_row    <= i_pos_y;
                    r_scale  <= i_scale;
                    r_full   <= 1'b0;
                end
            end
            if (i_cmd.draw_end) begin
                r_cursor <= n_cursor;
                if (!n_cursor[9] && n_cursor[8:7] != 2'b00) begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.sweep_init) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_issue) begin
            r_rot_rd <= i_rotate;
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_rot_rd ? {<<{w_rdata}} : w_rdata;
        end
        if (i_cmd.draw_init) begin
            r_gcol <= '0;
            r_sx   <= '0;
            r_x    <= r_cursor;
            r_page <= '0;
        end
        if (i_cmd.col_start) begin
            r_bit    <= '0;
            r_offset <= 9'(r_row);
            r_column <= '0;
        end
        if (i_cmd.col_step) begin
            r_bit    <= r_bit + 1'b1;
            r_offset <= r_offset + 9'(r_scale);
            if (w_gbyte[r_bit]) begin
                r_column <= r_column | w_ext[COL_W+7:8];
            end
        end
        if (i_cmd.page_next) begin
            r_page <= r_page + 1'b1;
        end
        if (i_cmd.x_step) begin
            r_x    <= r_x + 10'sd1;
            r_page <= '0;
            if (o_sts.sx_last) begin
                r_sx   <= '0;
                r_gcol <= r_gcol + 1'b1;
            end else begin
                r_sx <= r_sx + 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.sweep_last = (r_sweep == ADDR_W'(FRAME_BYTES - 1));
        o_sts.draw_skip  = (r_scale == 3'd0) || r_full;
        o_sts.bit_last   = (r_bit == 3'(GLYPH_ROWS - 1));
        o_sts.page_last  = (r_page == 3'(PAGE_COUNT - 1));
        o_sts.page_hit   = w_x_in && (w_page_bits != 8'd0);
        o_sts.sx_last    = (r_sx == r_scale - 3'd1);
        o_sts.gcol_last  = (r_gcol == 3'(GLYPH_COLS - 1));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
endmodule
`default_nettype wire

// File: rtl/sgb_ctrl.sv
`default_nettype none
module sgb_ctrl
    import sgb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic [1:0] i_op,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);
    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DSTART = 9'b000000100,
        S_BUILD  = 9'b000001000,
        S_PRD    = 9'b000010000,
        S_PWR    = 9'b000100000,
        S_XNEXT  = 9'b001000000,
        S_DEND   = 9'b010000000,
        S_RDATA  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            o_cmd.sweep_init = 1'b1;
                            n_state = S_CLR;
                        end
                        OP_DRAW: begin
                            o_cmd.start_item = 1'b1;
                            n_state = S_DSTART;
                        end
                        OP_READ: begin
                            o_cmd.read_issue = 1'b1;
                            n_state = S_RDATA;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DSTART: begin
                if (i_sts.draw_skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.draw_init = 1'b1;
                    o_cmd.col_start = 1'b1;
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                o_cmd.col_step = 1'b1;
                if (i_sts.bit_last) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (i_sts.page_hit) begin
                    o_cmd.page_rd = 1'b1;
                    n_state = S_PWR;
                end else if (i_sts.page_last) begin
                    n_state = S_XNEXT;
                end else begin
                    o_cmd.page_next = 1'b1;
                end
            end
            S_PWR: begin
                o_cmd.page_wr = 1'b1;
                if (i_sts.page_last) begin
                    n_state = S_XNEXT;
                end else begin
                    o_cmd.page_next = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_XNEXT: begin
                o_cmd.x_step = 1'b1;
                if (i_sts.sx_last && i_sts.gcol_last) begin
                    n_state = S_DEND;
                end else if (i_sts.sx_last) begin
                    o_cmd.col_start = 1'b1;
                    n_state = S_BUILD;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_DEND: begin
                o_cmd.draw_end = 1'b1;
                n_state = S_IDLE;
            end
            S_RDATA: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// File: rtl/scaled_glyph_blitter_core.sv
`default_nettype none
// Scaled glyph blitter. The block keeps a 128x64 one-bit frame in a 1024-byte
// memory organised in 8-row pages (byte = column + page * 128, bit 0 on top).
// Items arrive on the input channel one at a time: a clear zeroes the frame, a
// draw ORs one 5x7 font character, magnified by the string's scale, in at the
// text cursor and moves the cursor on by six times the scale, and a read gives
// one frame byte on the output channel, turned by a half turn while the
// rotate_half_turn register (reset 1) is set. Everything is done through the
// single-port-write frame memory, so the memory port sets the rate. After
// reset the block runs a clearing pass over every frame byte and holds
// o_in_stall high meanwhile; a clear item likewise sweeps the whole frame.
// A read loads its byte into the output register once that register is free,
// so an output stall delays it. A draw builds each of the five glyph columns
// from its seven rows and writes it out s times for scale s, visiting each page
// of the column; each touched byte costs one read and one write. A zero scale
// or a full line skips the draw, and an unused op is dropped. The output register
// lets the block take further items while a read result waits to be transferred.
module scaled_glyph_blitter_core
    import sgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_char_code,
    input  wire logic signed [7:0] i_pos_x,
    input  wire logic signed [6:0] i_pos_y,
    input  wire logic [2:0]        i_scale,
    input  wire logic              i_first_char,
    input  wire logic [9:0]        i_byte_addr,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_read_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [0:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;
    logic    r_rotate;

    // The only register sits at byte address zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
            r_rotate <= pwdata[0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr == 1'b0) ? {31'd0, r_rotate} : 32'd0;
    assign o_in_stall = w_busy;

    sgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    sgb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_char_code  (i_char_code),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_scale      (i_scale),
        .i_first_char (i_first_char),
        .i_byte_addr  (i_byte_addr),
        .i_rotate     (r_rotate),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_read_data  (o_read_data)
    );

    // A result only appears after the controller loaded the output register.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid rose without a load");

    // A clear item occupies the block for its sweep.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_op == OP_CLEAR) |=> o_in_stall)
        else $error("clear transfer did not start the sweep");

    // The clearing pass after reset keeps the input stalled.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input not stalled during the clearing pass");

    // The frame memory is never written while the block waits for items.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> !(w_cmd.sweep_step || w_cmd.page_wr))
        else $error("frame write while idle");
endmodule
`default_nettype wire
